// ===== rtl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// shared constants and configuration register indices for the envelope level unit
// ----------------------------------------------------------------------------
`default_nettype none
package adsr_pkg;
	localparam int TIME_BITS_DEF = 32;
	localparam int LEVEL_FRAC_BITS_DEF = 15;
	localparam int TICK_W = 24;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/adsr_div_cell.sv =====
// ----------------------------------------------------------------------------
// adsr_div_cell
// one restoring division step: a quotient bit per cycle while en is high, handed to the next cell
// ----------------------------------------------------------------------------
`default_nettype none
module adsr_div_cell #(
	parameter int NUM_W = 48,
	parameter int SIDE_W = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      vld_i,
	input  wire logic [adsr_pkg::DIV_W:0]  rem_i,
	input  wire logic [NUM_W-1:0]          num_i,
	input  wire logic [adsr_pkg::DIV_W-1:0] den_i,
	input  wire logic [SIDE_W-1:0]         side_i,
	output logic                           vld_o,
	output logic [adsr_pkg::DIV_W:0]       rem_o,
	output logic [NUM_W-1:0]               num_o,
	output logic [adsr_pkg::DIV_W-1:0]     den_o,
	output logic [SIDE_W-1:0]              side_o
);
	import adsr_pkg::*;
	logic [DIV_W+1:0] trial;
	logic [DIV_W+1:0] diff;
	logic             ge;

	always_comb begin
		trial = {rem_i, num_i[NUM_W-1]};
		diff = trial - {2'b00, den_i};
		ge = !diff[DIV_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[DIV_W:0] : trial[DIV_W:0];
			num_o <= {num_i[NUM_W-2:0], ge};
			den_o <= den_i;
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/adsr_envelope_level_unit.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_level_unit
// piecewise-linear adsr level, pipelined through a chain of division cells
// ----------------------------------------------------------------------------
//  channel  | transfer on           | payload
//  s_axis   | s_tvalid & s_tready   | tdata: note_time, key_released, release_at
//  m_axis   | m_tvalid & m_tready   | tdata: level, finished
//  cfg      | cfg_we                | cfg_idx selects register, cfg_data
//
// one item per cycle while the output is not stalled; each item passes the decide stage,
// the first multiply stage, the first division chain (one cell per quotient bit), the
// release multiply stage, the second division chain and the output register.
// the whole pipe advances when the output register is empty or taken, so a
// stall on m_tready holds every stage; s_tready follows that same enable.
// reset clears the valid bits and loads register reset values.
`default_nettype none
module adsr_envelope_level_unit #(
	parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// note_time, key_released, release_at from bit 0, zero fill
	input  wire logic [((2*TIME_BITS+1+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// level, finished from bit 0, zero fill
	output logic [((LEVEL_FRAC_BITS+2+7)/8)*8-1:0] m_tdata,
	input  wire logic cfg_we,
	input  wire logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [adsr_pkg::CFG_W-1:0] cfg_data
);
	import adsr_pkg::*;
	localparam int TB = TIME_BITS;
	localparam int LW = LEVEL_FRAC_BITS + 1;
	localparam int SW = 16;
	// wide enough for a time or a tick count plus one carry bit
	localparam int TW = ((TB > TICK_W) ? TB : TICK_W) + 1;
	// numerator of a ramp: level times ticks, at most LW + TICK_W bits
	localparam int NW = LW + TICK_W;
	localparam int OW = ((LEVEL_FRAC_BITS + 2 + 7) / 8) * 8;
	localparam logic [LW-1:0] FULL = LW'(1) << LEVEL_FRAC_BITS;

	// configuration registers
	logic [TICK_W-1:0] att_q, dec_q, rel_q;
	logic [SW-1:0]     sus_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q <= '0;
			dec_q <= '0;
			sus_q <= SW'(32768);
			rel_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ATTACK:  att_q <= cfg_data;
				REG_DECAY:   dec_q <= cfg_data;
				REG_SUSTAIN: sus_q <= cfg_data[SW-1:0];
				REG_RELEASE: rel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [LW-1:0] s_sat;
	always_comb s_sat = (32'(sus_q) > 32'(FULL)) ? FULL : LW'(sus_q);

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [TB-1:0] t_in, r_in;
	logic          k_in;
	assign t_in = s_tdata[TB-1:0];
	assign k_in = s_tdata[TB];
	assign r_in = s_tdata[2*TB:TB+1];

	// stage 1: decide phases. held chain evaluated at u = released-in-window ? r : t
	typedef enum logic [1:0] {H_ATT, H_DEC, H_SUS} hph_t;
	logic          v_s1, rel_s1, done_s1;
	hph_t          ph_s1;
	logic [TW-1:0] u_s1, relrem_s1;
	logic [TW-1:0] r_end, t_w, r_w, u_c, ad;
	logic          inrel, done_c;
	hph_t          ph_c;
	always_comb begin
		t_w = TW'(t_in);
		r_w = TW'(r_in);
		r_end = r_w + TW'(rel_q);
		done_c = k_in && (t_w > r_end);
		inrel = k_in && !done_c && (t_w > r_w);
		u_c = inrel ? r_w : t_w;
		ad = TW'(att_q) + TW'(dec_q);
		if (u_c < TW'(att_q)) ph_c = H_ATT;
		else if (u_c < ad) ph_c = H_DEC;
		else ph_c = H_SUS;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rel_s1 <= inrel;
			done_s1 <= done_c;
			ph_s1 <= ph_c;
			u_s1 <= (ph_c == H_ATT) ? u_c : (ad - u_c);
			relrem_s1 <= r_end - t_w;
		end
	end

	// stage 2: first numerator multiply (offsets fit 24 bits in ramp phases)
	logic          v_s2, rel_s2, done_s2;
	hph_t          ph_s2;
	logic [NW-1:0] num_s2;
	logic [DIV_W-1:0] den_s2;
	logic [TICK_W-1:0] rrem_s2;
	logic [LW-1:0] s_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rel_s2 <= rel_s1;
			done_s2 <= done_s1;
			ph_s2 <= ph_s1;
			s_s2 <= s_sat;
			rrem_s2 <= relrem_s1[TICK_W-1:0];
			unique case (ph_s1)
				H_ATT: begin
					num_s2 <= NW'(FULL) * NW'(u_s1[TICK_W-1:0]);
					den_s2 <= att_q;
				end
				H_DEC: begin
					num_s2 <= NW'(FULL - s_sat) * NW'(u_s1[TICK_W-1:0]);
					den_s2 <= dec_q;
				end
				default: begin
					num_s2 <= '0;
					den_s2 <= DIV_W'(1);
				end
			endcase
		end
	end

	// first division chain: one cell per quotient bit
	localparam int SIDE1 = 4 + LW + TICK_W;
	logic [NW-1:0]    n1 [NW+1];
	logic [DIV_W:0]   rm1 [NW+1];
	logic [DIV_W-1:0] d1 [NW+1];
	logic [SIDE1-1:0] sd1 [NW+1];
	logic             v1 [NW+1];
	assign n1[0] = num_s2;
	assign rm1[0] = '0;
	assign d1[0] = den_s2;
	assign v1[0] = v_s2;
	assign sd1[0] = {rel_s2, done_s2, ph_s2, s_s2, rrem_s2};
	for (genvar i = 0; i < NW; i++) begin : g_div1
		adsr_div_cell #(.NUM_W(NW), .SIDE_W(SIDE1)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(v1[i]), .rem_i(rm1[i]), .num_i(n1[i]), .den_i(d1[i]), .side_i(sd1[i]),
			.vld_o(v1[i+1]), .rem_o(rm1[i+1]), .num_o(n1[i+1]), .den_o(d1[i+1]),
			.side_o(sd1[i+1])
		);
	end

	// stage 3: held level, then release numerator
	logic              rel_a, done_a;
	hph_t              ph_a;
	logic [LW-1:0]     s_a, hl;
	logic [TICK_W-1:0] rrem_a;
	assign {rel_a, done_a, ph_a, s_a, rrem_a} = sd1[NW];
	always_comb begin
		unique case (ph_a)
			H_ATT:   hl = n1[NW][LW-1:0];
			H_DEC:   hl = s_a + n1[NW][LW-1:0];
			default: hl = s_a;
		endcase
	end
	logic          v_s3, rel_s3, done_s3;
	logic [LW-1:0] hl_s3;
	logic [NW-1:0] num_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v1[NW];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rel_s3 <= rel_a;
			done_s3 <= done_a;
			hl_s3 <= hl;
			num_s3 <= NW'(hl) * NW'(rrem_a);
		end
	end

	// second division chain for the release ramp
	localparam int SIDE2 = 2 + LW;
	logic [NW-1:0]    n2 [NW+1];
	logic [DIV_W:0]   rm2 [NW+1];
	logic [DIV_W-1:0] d2 [NW+1];
	logic [SIDE2-1:0] sd2 [NW+1];
	logic             v2 [NW+1];
	assign n2[0] = rel_s3 ? num_s3 : '0;
	assign rm2[0] = '0;
	assign d2[0] = rel_s3 ? rel_q : DIV_W'(1);
	assign v2[0] = v_s3;
	assign sd2[0] = {rel_s3, done_s3, hl_s3};
	for (genvar i = 0; i < NW; i++) begin : g_div2
		adsr_div_cell #(.NUM_W(NW), .SIDE_W(SIDE2)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(v2[i]), .rem_i(rm2[i]), .num_i(n2[i]), .den_i(d2[i]), .side_i(sd2[i]),
			.vld_o(v2[i+1]), .rem_o(rm2[i+1]), .num_o(n2[i+1]), .den_o(d2[i+1]),
			.side_o(sd2[i+1])
		);
	end

	// output register
	logic          rel_b, done_b;
	logic [LW-1:0] hl_b, lvl;
	assign {rel_b, done_b, hl_b} = sd2[NW];
	always_comb begin
		if (done_b) lvl = '0;
		else if (rel_b) lvl = n2[NW][LW-1:0];
		else lvl = hl_b;
		if (lvl > FULL) lvl = FULL;
	end
	logic [LW-1:0] lvl_q;
	logic          fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v2[NW];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lvl_q <= lvl;
			fin_q <= done_b;
		end
	end
	assign m_tdata = OW'({fin_q, lvl_q});
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// adsr envelope level bench
// drives note time / release items through the envelope unit under several
// envelope settings, predicts each level and finished flag, and checks every
// transfer on the output stream in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
	import adsr_pkg::*;

	localparam longint unsigned FULL = 64'd32768;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [31:0] note_time;
		logic        key_released;
		logic [31:0] release_at;
	} note_item_t;

	typedef struct packed {
		logic        finished;
		logic [15:0] level;
	} env_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_ATTACK;
	logic [CFG_W-1:0] cfg_data = '0;

	// envelope settings as the block holds them
	longint unsigned atk_len = 0;
	longint unsigned dec_len = 0;
	longint unsigned sus_lvl = 32768;
	longint unsigned rel_len = 0;

	note_item_t notes_to_send[$];
	env_out_t   levels_due[$];
	logic idle_on = 1'b1;
	int src_gap = 0;
	int sink_gap = 0;
	int long_hold = 0;
	int levels_seen = 0;
	int errors = 0;
	int cycles = 0;
	int finished_seen = 0;
	int phases_run = 0;

	adsr_envelope_level_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// level with the key held at tick t
	function automatic longint unsigned held_env(longint unsigned t);
		longint unsigned s;
		s = (sus_lvl > FULL) ? FULL : sus_lvl;
		if (t < atk_len) return (FULL * t) / atk_len;
		if (t < atk_len + dec_len)
			return s + ((FULL - s) * (atk_len + dec_len - t)) / dec_len;
		return s;
	endfunction

	function automatic env_out_t envelope_of(note_item_t it);
		longint unsigned t;
		longint unsigned r;
		longint unsigned lvl;
		env_out_t o;
		t = it.note_time;
		r = it.release_at;
		o.finished = 1'b0;
		if (it.key_released && t > r + rel_len) begin
			lvl = 0;
			o.finished = 1'b1;
		end else if (it.key_released && t > r) begin
			// inside the release ramp, starting from the held level at r
			lvl = (held_env(r) * (r + rel_len - t)) / rel_len;
		end else begin
			lvl = held_env(t);
		end
		if (lvl > FULL) lvl = FULL;
		o.level = lvl[15:0];
		return o;
	endfunction

	// tick picked around the segment edges of the current setting
	function automatic logic [31:0] pick_tick();
		longint unsigned edge_pt;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 3);
			2: edge_pt = atk_len;
			3: edge_pt = atk_len + dec_len;
			4: return $urandom_range(0, 32'(atk_len + dec_len + 8));
			default: edge_pt = atk_len / 2 + dec_len;
		endcase
		return 32'(edge_pt) + 32'($urandom_range(0, 6)) - 32'd3;
	endfunction

	function automatic note_item_t random_note();
		note_item_t it;
		it.key_released = $urandom_range(0, 2) != 0;
		it.release_at = pick_tick();
		case ($urandom_range(0, 4))
			0: it.note_time = pick_tick();
			1: it.note_time = $urandom;
			// right at and around the end of release
			2: it.note_time = it.release_at + 32'(rel_len) + 32'($urandom_range(0, 2)) - 32'd1;
			default: it.note_time = it.release_at + 32'($urandom_range(0, 32'(rel_len) + 2));
		endcase
		return it;
	endfunction

	function automatic note_item_t mk(logic [31:0] t, logic k, logic [31:0] r);
		note_item_t it;
		it.note_time = t;
		it.key_released = k;
		it.release_at = r;
		return it;
	endfunction

	// source side: one transfer per accepted item, prediction taken at acceptance
	always @(posedge clk or negedge arst_n) begin
		note_item_t cur;
		logic next_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			cur = note_item_t'({s_tdata[31:0], s_tdata[32], s_tdata[64:33]});
			if (s_tvalid && s_tready)
				levels_due.push_back(envelope_of(cur));
			if (!(s_tvalid && !s_tready)) begin
				next_valid = 1'b0;
				if (src_gap > 0) begin
					src_gap--;
				end else if (idle_on && $urandom_range(0, 11) == 0) begin
					src_gap = $urandom_range(1, 18);
				end else if (notes_to_send.size() > 0) begin
					cur = notes_to_send.pop_front();
					next_valid = 1'b1;
				end
				s_tvalid <= next_valid;
				s_tdata <= {7'd0, cur.release_at, cur.key_released, cur.note_time};
			end
		end
	end

	// sink side: random stalls, and one long hold-off to back the pipe up
	always @(posedge clk or negedge arst_n) begin
		env_out_t got;
		env_out_t want;
		logic next_ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t timeout with %0d levels outstanding", $time, levels_due.size());
				$display("[adsr_envelope_level_unit] ERROR");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				got = env_out_t'(m_tdata[16:0]);
				levels_seen++;
				if (got.finished) finished_seen++;
				if (levels_due.size() == 0) begin
					$display("%0t unexpected transfer level %0d finished %0b",
						$time, got.level, got.finished);
					errors++;
				end else begin
					want = levels_due.pop_front();
					if (got.level !== want.level) begin
						$display("%0t level mismatch: expected %0d actual %0d",
							$time, want.level, got.level);
						errors++;
					end
					if (got.finished !== want.finished) begin
						$display("%0t finished mismatch: expected %0b actual %0b",
							$time, want.finished, got.finished);
						errors++;
					end
				end
				if (levels_seen == 300) long_hold = 400;
			end
			next_ready = 1'b1;
			if (long_hold > 0) begin
				long_hold--;
				next_ready = 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				next_ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(1, 18);
				next_ready = 1'b0;
			end
			m_tready <= next_ready;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[CFG_W-1:0];
		case (idx)
			REG_ATTACK: atk_len = val & 24'hFFFFFF;
			REG_DECAY: dec_len = val & 24'hFFFFFF;
			REG_SUSTAIN: sus_lvl = val & 16'hFFFF;
			default: rel_len = val & 24'hFFFFFF;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_envelope(longint unsigned a, longint unsigned d,
			longint unsigned s, longint unsigned r);
		write_reg(REG_ATTACK, a);
		write_reg(REG_DECAY, d);
		write_reg(REG_SUSTAIN, s);
		write_reg(REG_RELEASE, r);
	endtask

	// sender holds off until the pipe has emptied, checked between edges
	task automatic drain();
		do @(negedge clk);
		while (!(notes_to_send.size() == 0 && !s_tvalid && levels_due.size() == 0));
		repeat (4) @(posedge clk);
		phases_run++;
	endtask

	task automatic random_phase(int n);
		repeat (n) notes_to_send.push_back(random_note());
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: every segment instant, sustain full scale
		notes_to_send.push_back(mk(32'd0, 1'b0, 32'd0));
		notes_to_send.push_back(mk(32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF));
		notes_to_send.push_back(mk(32'd5, 1'b1, 32'd5));
		notes_to_send.push_back(mk(32'd6, 1'b1, 32'd5));
		drain();

		set_envelope(10, 20, 8000, 30);
		notes_to_send.push_back(mk(32'd0, 1'b0, 32'hFFFFFFFF));
		notes_to_send.push_back(mk(32'd5, 1'b0, 32'd0));
		notes_to_send.push_back(mk(32'd10, 1'b0, 32'd0));
		notes_to_send.push_back(mk(32'd15, 1'b0, 32'd0));
		notes_to_send.push_back(mk(32'd30, 1'b0, 32'd0));
		notes_to_send.push_back(mk(32'd45, 1'b0, 32'd0));
		notes_to_send.push_back(mk(32'hFFFFFFFF, 1'b0, 32'd0));
		// release during attack, decay and sustain
		notes_to_send.push_back(mk(32'd6, 1'b1, 32'd5));
		notes_to_send.push_back(mk(32'd20, 1'b1, 32'd15));
		notes_to_send.push_back(mk(32'd50, 1'b1, 32'd40));
		// end of release exactly, then one past it
		notes_to_send.push_back(mk(32'd35, 1'b1, 32'd5));
		notes_to_send.push_back(mk(32'd36, 1'b1, 32'd5));
		// release tick still ahead of note time
		notes_to_send.push_back(mk(32'd3, 1'b1, 32'd5));
		notes_to_send.push_back(mk(32'd0, 1'b1, 32'hFFFFFFFF));
		notes_to_send.push_back(mk(32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF));
		notes_to_send.push_back(mk(32'hFFFFFFFF, 1'b1, 32'd0));
		drain();

		random_phase(400);
		set_envelope(1, 1, 0, 1);
		random_phase(150);
		set_envelope(24'hFFFFFF, 24'hFFFFFF, 32768, 24'hFFFFFF);
		random_phase(150);
		// sustain above full scale saturates
		set_envelope(1000, 3000, 16'hFFFF, 500);
		random_phase(150);
		set_envelope(0, 40, 1, 0);
		random_phase(150);
		set_envelope(25, 0, 20000, 7);
		random_phase(150);
		repeat (3) begin
			set_envelope($urandom_range(0, 300), $urandom_range(0, 300),
				$urandom_range(0, 32768), $urandom_range(0, 300));
			random_phase(150);
		end
		set_envelope($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 16'hFFFF), $urandom_range(0, 24'hFFFFFF));
		random_phase(100);

		// closing stretch at full rate, no idling on either side
		idle_on <= 1'b0;
		set_envelope(8, 12, 12000, 16);
		random_phase(150);

		repeat (200) @(posedge clk);
		$display("covered %0d phases, %0d levels checked, %0d finished",
			phases_run, levels_seen, finished_seen);
		$display("settings included instant segments, maximal lengths and saturated sustain");
		if (errors == 0 && levels_due.size() == 0) begin
			$display("[adsr_envelope_level_unit] OK");
		end else begin
			$display("[adsr_envelope_level_unit] ERROR");
		end
		$finish;
	end
endmodule
